// ----- rtl/sgm_pkg.sv -----
// Shared constants, types and register indexes for the Sobel gradient magnitude block.
// No dependencies.
`timescale 1ns / 1ps
package sgm_pkg;
    localparam int MaxWidth    = 1024;
    localparam int MaxHeight   = 4096;
    localparam int ColW        = $clog2(MaxWidth);
    localparam int RowW        = $clog2(MaxHeight);
    localparam int SqW         = 16;
    localparam int RootW       = SqW / 2;
    localparam int RemW        = RootW + 1;
    localparam int NumCells    = RootW;

    localparam logic [7:0] RegWidth  = 8'd0;
    localparam logic [7:0] RegHeight = 8'd1;

    typedef struct packed {
        logic       valid;
        logic       row_end;
        logic       frame_end;
    } t_tag;

    // Data that travels down the square-root cell chain. The radicand is
    // consumed two bits per cell from its top end.
    typedef struct packed {
        t_tag              tag;
        logic [SqW-1:0]    rad;
        logic [RemW-1:0]   rem;
        logic [RootW-1:0]  root;
    } t_sqrt_beat;
endpackage

// ----- rtl/sgm_sqrt_cell.sv -----
// One cell of the square-root chain: settles one result bit per cycle while enabled.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
module sgm_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  sgm_pkg::t_sqrt_beat i_beat,
    output sgm_pkg::t_sqrt_beat o_beat
);
    import sgm_pkg::*;

    logic [RemW+1:0]     w_acc;
    logic [RemW+1:0]     w_trial;
    t_sqrt_beat          n_beat;
    t_sqrt_beat          r_beat;

    // The remainder takes the next two radicand bits; the trial value is 4*root + 1.
    assign w_acc   = {i_beat.rem, i_beat.rad[SqW-1 -: 2]};
    assign w_trial = {1'b0, i_beat.root, 2'b01};

    always_comb begin
        n_beat     = i_beat;
        n_beat.rad = {i_beat.rad[SqW-3:0], 2'b00};
        if (w_acc >= w_trial) begin
            n_beat.rem  = RemW'(w_acc - w_trial);
            n_beat.root = {i_beat.root[RootW-2:0], 1'b1};
        end else begin
            n_beat.rem  = w_acc[RemW-1:0];
            n_beat.root = {i_beat.root[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.tag <= '0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;
endmodule

// ----- rtl/sgm_window.sv -----
// Line stores, 3x3 window and Sobel sums; emits the saturated sum of squares with tags.
// Depends on sgm_pkg.
`timescale 1ns / 1ps
module sgm_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_restart,
    input  logic [10:0]         i_width,
    input  logic [12:0]         i_height,
    input  logic                i_pix_valid,
    input  logic [7:0]          i_pix,
    output sgm_pkg::t_sqrt_beat o_beat
);
    import sgm_pkg::*;

    logic [7:0]          r_store_a [MaxWidth];
    logic [7:0]          r_store_b [MaxWidth];
    logic [7:0]          r_win [6];
    logic [ColW-1:0]     r_col;
    logic [ColW-1:0]     n_col;
    logic [RowW-1:0]     r_row;
    logic [RowW-1:0]     n_row;
    logic [ColW:0]       w_w;
    logic [RowW:0]       w_h;
    logic [7:0]          r_top;
    logic [7:0]          r_mid;
    logic                w_take;
    logic                w_last_col;
    logic                w_last_row;
    logic signed [11:0]  w_gx;
    logic signed [11:0]  w_gy;
    logic signed [11:0]  r_gx;
    logic signed [11:0]  r_gy;
    logic [9:0]          w_ax;
    logic [9:0]          w_ay;
    t_tag                r_tag0;
    t_tag                r_tag1;
    logic [19:0]         r_sqx;
    logic [19:0]         r_sqy;
    logic [20:0]         w_sum;
    t_sqrt_beat          r_beat;

    assign w_take = i_en && i_pix_valid;

    always_comb begin
        w_w = (i_width < 11'd3) ? (ColW+1)'(3)
            : (i_width > 11'(MaxWidth)) ? (ColW+1)'(MaxWidth) : (ColW+1)'(i_width);
        w_h = (i_height < 13'd3) ? (RowW+1)'(3)
            : (i_height > 13'(MaxHeight)) ? (RowW+1)'(MaxHeight) : (RowW+1)'(i_height);
    end

    assign w_last_col = ({1'b0, r_col} == w_w - 1'b1);
    assign w_last_row = ({1'b0, r_row} == w_h - 1'b1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_take) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // The stores are read ahead at the next column, so r_top and r_mid
    // always hold the entries of the current column. The next column never
    // equals the column being written, since a row has at least three pixels.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_store_b[r_col] <= r_mid;
            r_store_a[r_col] <= i_pix;
        end
        r_top <= r_store_b[n_col];
        r_mid <= r_store_a[n_col];
    end

    always_comb begin
        w_gx = $signed({4'b0, r_win[4]}) + $signed({3'b0, r_win[5], 1'b0})
             + $signed({4'b0, i_pix})
             - $signed({4'b0, r_win[0]}) - $signed({3'b0, r_win[1], 1'b0})
             - $signed({4'b0, r_top});
        w_gy = $signed({4'b0, r_win[0]}) + $signed({3'b0, r_win[2], 1'b0})
             + $signed({4'b0, r_win[4]})
             - $signed({4'b0, r_top}) - $signed({3'b0, r_mid, 1'b0})
             - $signed({4'b0, i_pix});
    end

    // Both sums are at most 1020 in size, so their magnitudes fit 10 bits.
    assign w_ax  = r_gx[11] ? 10'(-r_gx) : 10'(r_gx);
    assign w_ay  = r_gy[11] ? 10'(-r_gy) : 10'(r_gy);
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '{default: '0};
            r_col      <= '0;
            r_row      <= '0;
            r_tag0     <= '0;
            r_tag1     <= '0;
            r_beat.tag <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_take) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_top;
                r_win[2] <= r_win[3];
                r_win[3] <= r_mid;
                r_win[4] <= r_win[5];
                r_win[5] <= i_pix;
            end
            if (i_en) begin
                r_tag0.valid     <= w_take && r_row >= RowW'(2) && r_col >= ColW'(2);
                r_tag0.row_end   <= w_last_col;
                r_tag0.frame_end <= w_last_col && w_last_row;
                r_gx             <= w_gx;
                r_gy             <= w_gy;
                r_tag1           <= r_tag0;
                r_sqx            <= {10'b0, w_ax} * {10'b0, w_ay & 10'b0 | w_ax};
                r_sqy            <= {10'b0, w_ay} * {10'b0, w_ay};
                r_beat.tag       <= r_tag1;
                // Anything at or above 256*256 saturates the root at 255.
                r_beat.rad       <= (w_sum > 21'(16'hFFFF)) ? {SqW{1'b1}} : w_sum[SqW-1:0];
                r_beat.rem       <= '0;
                r_beat.root      <= '0;
            end
        end
    end

    assign o_beat = r_beat;
endmodule

// ----- rtl/sobel_gradient_magnitude.sv -----
// Top level of the Sobel 3x3 gradient magnitude block.
// Depends on sgm_pkg; instances of sgm_window and sgm_sqrt_cell.
`timescale 1ns / 1ps
//  channel | direction | signals
//  pixel   | in        | i_valid, o_ready, i_pixel
//  result  | out       | o_valid, i_ready, o_magnitude, o_row_end, o_frame_end
//  config  | in        | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
// One pixel per cycle is taken unless pixels are held off. A result is presented once
// the pixel that completes its window has passed the sums, squares and saturation,
// three register stages, and eight square-root cells that settle one result bit each.
// Reset is synchronous and active low; the whole pipeline stalls while a
// finished result is not taken, and pixels are then held off. Pixels are also
// held off in a cycle that carries a write to the width or height register.
module sobel_gradient_magnitude (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_magnitude,
    output logic        o_row_end,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sgm_pkg::*;

    logic [10:0]        r_width;
    logic [12:0]        r_height;
    logic               w_en;
    logic               w_take;
    logic               w_cfg;
    t_sqrt_beat         w_chain [NumCells+1];

    assign o_cfg_ready = 1'b1;
    assign w_cfg  = i_cfg_valid && (i_cfg_index == RegWidth || i_cfg_index == RegHeight);
    // The chain moves whenever the output slot is free or being emptied.
    assign w_en   = !w_chain[NumCells].tag.valid || i_ready;
    assign o_ready = w_en && !w_cfg;
    assign w_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
        end else if (w_cfg) begin
            if (i_cfg_index == RegWidth) begin
                r_width <= i_cfg_data[10:0];
            end else begin
                r_height <= i_cfg_data[12:0];
            end
        end
    end

    sgm_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_restart  (w_cfg),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_pix_valid(w_take),
        .i_pix      (i_pixel),
        .o_beat     (w_chain[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        sgm_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_beat (w_chain[g]),
            .o_beat (w_chain[g+1])
        );
    end

    assign o_valid     = w_chain[NumCells].tag.valid;
    assign o_magnitude = w_chain[NumCells].root;
    assign o_row_end   = w_chain[NumCells].tag.row_end;
    assign o_frame_end = w_chain[NumCells].tag.frame_end;
endmodule

// ----- tb/sgm_scoreboard.sv -----
// Checker for the Sobel gradient magnitude block: watches the pixel, result and
// register channels, predicts every result and compares it field by field.
// Depends on sgm_pkg for the register indexes and the line store depth.
`timescale 1ns / 1ps
module sgm_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_pixel,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_magnitude,
    input  logic        o_row_end,
    input  logic        o_frame_end,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import sgm_pkg::*;

    typedef struct {
        logic [7:0] magnitude;
        logic       row_end;
        logic       frame_end;
    } t_grad;

    t_grad       grad_q[$];
    logic [7:0]  prev_row[MaxWidth];
    logic [7:0]  older_row[MaxWidth];
    logic [7:0]  win[6];
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    int          col_cnt;
    int          row_cnt;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    task automatic flag(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        o_errors++;
    endtask

    // Advances the window by one pixel and queues the gradient it completes.
    task automatic take_pixel(input logic [7:0] bot_px);
        int    w, h, c, r, tl, tc, tr, ml, mr, bl, bc, br, gx, gy, sq, mag;
        t_grad g;
        w = (width_reg < 3) ? 3 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MaxHeight) ? MaxHeight : height_reg;
        c = (col_cnt >= w) ? 0 : col_cnt;
        r = (row_cnt >= h) ? 0 : row_cnt;
        tr = older_row[c];
        mr = prev_row[c];
        br = bot_px;
        older_row[c] = prev_row[c];
        prev_row[c]  = bot_px;
        tl = win[0]; tc = win[1]; ml = win[2]; bl = win[4]; bc = win[5];
        if (r >= 2 && c >= 2) begin
            gx = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
            gy = (tl + 2 * ml + bl) - (tr + 2 * mr + br);
            sq = gx * gx + gy * gy;
            mag = 0;
            while (mag < 255 && (mag + 1) * (mag + 1) <= sq) mag++;
            g.magnitude = mag[7:0];
            g.row_end   = (c == w - 1);
            g.frame_end = (c == w - 1) && (r == h - 1);
            grad_q = {grad_q, g};
        end
        win[0] = win[1]; win[1] = tr[7:0];
        win[2] = win[3]; win[3] = mr[7:0];
        win[4] = win[5]; win[5] = bot_px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    always @(posedge i_clk) begin
        t_grad g;
        if (!i_rst_n) begin
            grad_q.delete();
            foreach (win[k]) win[k] = '0;
            foreach (prev_row[k]) begin
                prev_row[k]  = '0;
                older_row[k] = '0;
            end
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = 11'd1024;
            height_reg = 13'd1024;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == RegWidth || i_cfg_index == RegHeight) begin
                    if (i_cfg_index == RegWidth) width_reg = i_cfg_data[10:0];
                    else height_reg = i_cfg_data[12:0];
                    col_cnt = 0;
                    row_cnt = 0;
                end
            end
            if (i_valid && o_ready) take_pixel(i_pixel);
            if (o_valid && i_ready) begin
                o_results++;
                if (grad_q.size() == 0) begin
                    flag($sformatf("result beat with nothing expected (magnitude %0d)",
                                   o_magnitude));
                end else begin
                    g = grad_q.pop_front();
                    if (o_magnitude !== g.magnitude)
                        flag($sformatf("magnitude %0d, expected %0d",
                                       o_magnitude, g.magnitude));
                    if (o_row_end !== g.row_end)
                        flag($sformatf("row_end %b, expected %b", o_row_end, g.row_end));
                    if (o_frame_end !== g.frame_end)
                        flag($sformatf("frame_end %b, expected %b",
                                       o_frame_end, g.frame_end));
                end
            end
        end
        o_pending = grad_q.size();
    end
endmodule

// ----- tb/testbench.sv -----
// Top of the Sobel gradient magnitude testbench: clock, reset, pixel and register
// stimulus, result back-pressure and the verdict. Depends on sgm_pkg, the block
// and sgm_scoreboard.
`timescale 1ns / 1ps
module testbench;
    import sgm_pkg::*;

    localparam logic [7:0] RegSpare = 8'd2;
    localparam int CycleLimit = 1000000;
    localparam int PixelTarget = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_pixel = '0;
    logic        o_valid;
    logic        rx_ready = 1'b0;
    logic        hold_off = 1'b0;
    logic        i_ready;
    logic [7:0]  o_magnitude;
    logic        o_row_end;
    logic        o_frame_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    int          errors, pending, results;
    int          cycles = 0;
    int          pixels_sent = 0;
    int          frames_sent = 0;
    int          tx_max_gap = 16;

    assign i_ready = rx_ready && !hold_off;

    sobel_gradient_magnitude dut (.*);

    sgm_scoreboard checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_pixel, .o_valid, .i_ready,
        .o_magnitude, .o_row_end, .o_frame_end, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random gaps before each beat, switching now and then to
    // stretches where it is always ready.
    initial begin
        int rx_max_gap, gap;
        rx_max_gap = 16;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_max_gap = (rx_max_gap == 0) ? 16 : 0;
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                rx_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rx_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // One long back-pressure stretch while pixels keep coming, so the chain fills.
    initial begin
        while (pixels_sent < PixelTarget - 80) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic push_pixel(input logic [7:0] px);
        int gap;
        i_cfg_valid <= 1'b0;
        if ($urandom_range(0, 63) == 0) tx_max_gap = (tx_max_gap == 0) ? 16 : 0;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        pixels_sent++;
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
    endtask

    // Let every expected result arrive, then give trailing pixels time to clear.
    task automatic drain();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_pixel(input bit extremes_only);
        int sel;
        sel = $urandom_range(0, 7);
        if (extremes_only || sel < 2) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_random(input int count, input bit extremes_only);
        repeat (count) push_pixel(pick_pixel(extremes_only));
    endtask

    initial begin
        int w, h, ew, eh, n_frames, part;
        bit extremes_only;
        logic [7:0] steps[9];
        logic [7:0] ramp[9];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame; upper register bits must be ignored.
        cfg_write(RegWidth, 16'hF803);
        cfg_write(RegHeight, 16'hE003);
        steps = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
        ramp  = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255};
        foreach (steps[k]) push_pixel(steps[k]);
        repeat (9) push_pixel(8'd255);
        foreach (ramp[k]) push_pixel(ramp[k]);
        repeat (9) push_pixel(8'd0);
        frames_sent += 4;
        drain();

        // Widest row, from a width value above the maximum, wrapping into a second row.
        cfg_write(RegWidth, 16'hFFFF);
        cfg_write(RegHeight, 16'd3);
        push_random(MaxWidth + 8, 1'b0);
        drain();

        // Tallest frame, cut short by the next register write.
        cfg_write(RegWidth, 16'd1);
        cfg_write(RegHeight, 16'hFFFF);
        push_random(36, 1'b0);
        drain();

        while (pixels_sent < PixelTarget) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            if ($urandom_range(0, 19) == 0) w = $urandom_range(13, 64);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            ew = (w < 3) ? 3 : w;
            eh = (h < 3) ? 3 : h;
            cfg_write(RegWidth, 16'(w));
            cfg_write(RegHeight, 16'(h) | 16'($urandom_range(0, 7) << 13));
            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                extremes_only = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 4) == 0) begin
                    part = $urandom_range(1, ew * eh - 1);
                    push_random(part, extremes_only);
                    drain();
                    if ($urandom_range(0, 1) != 0) break;
                    // A write to an unused index must not restart the frame.
                    cfg_write(RegSpare, 16'($urandom()));
                    push_random(ew * eh - part, extremes_only);
                end else begin
                    push_random(ew * eh, extremes_only);
                end
                frames_sent++;
            end
            drain();
        end

        drain();
        $display("Sent %0d pixels in %0d full frames plus cut-short frames; %0d gradients",
                 pixels_sent, frames_sent, results);
        $display("checked, with clamped widths and heights and one long output stall.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/sgm_pkg.sv
rtl/sgm_sqrt_cell.sv
rtl/sgm_window.sv
rtl/sobel_gradient_magnitude.sv
tb/sgm_scoreboard.sv
tb/testbench.sv
